>>> rtl/rv32ex_pkg.sv
// Shared constants and types for the RV32I execute unit.
// Holds operation codes, trap codes and field widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rv32ex_pkg;

   localparam int unsigned XLEN              = 32;
   localparam int unsigned OP_WIDTH          = 6;
   localparam int unsigned REG_IDX_WIDTH     = 5;
   localparam int unsigned REG_COUNT         = 32;
   localparam int unsigned IMM_WIDTH         = 21;
   localparam int unsigned UPPER_WIDTH       = 20;
   localparam int unsigned UPPER_SHIFT       = 12;
   localparam int unsigned TRAP_WIDTH        = 2;
   localparam int unsigned MEM_BYTES_DEFAULT = 4096;
   localparam int unsigned BANK_COUNT        = 4;
   localparam int unsigned CSR_ADDR_WIDTH    = 3;

   // Register index as decoded from paddr[2].
   localparam logic CSR_START_ADDRESS = 1'b0;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 6'd0,  OP_SUB   = 6'd1,  OP_XOR   = 6'd2,  OP_OR    = 6'd3,
      OP_AND   = 6'd4,  OP_SLL   = 6'd5,  OP_SRL   = 6'd6,  OP_SRA   = 6'd7,
      OP_SLT   = 6'd8,  OP_SLTU  = 6'd9,  OP_ADDI  = 6'd10, OP_XORI  = 6'd11,
      OP_ORI   = 6'd12, OP_ANDI  = 6'd13, OP_SLLI  = 6'd14, OP_SRLI  = 6'd15,
      OP_SRAI  = 6'd16, OP_SLTI  = 6'd17, OP_SLTIU = 6'd18, OP_LB    = 6'd19,
      OP_LH    = 6'd20, OP_LW    = 6'd21, OP_LBU   = 6'd22, OP_LHU   = 6'd23,
      OP_JALR  = 6'd24, OP_ECALL = 6'd25, OP_EBREAK = 6'd26, OP_SB   = 6'd27,
      OP_SH    = 6'd28, OP_SW    = 6'd29, OP_BEQ   = 6'd30, OP_BNE   = 6'd31,
      OP_BLT   = 6'd32, OP_BGE   = 6'd33, OP_BLTU  = 6'd34, OP_BGEU  = 6'd35,
      OP_LUI   = 6'd36, OP_AUIPC = 6'd37, OP_JAL   = 6'd38
   } op_type;

   typedef enum logic [TRAP_WIDTH-1:0] {
      TRAP_NONE  = 2'd0,
      TRAP_ECALL = 2'd1,
      TRAP_BREAK = 2'd2
   } trap_type;

endpackage

`default_nettype wire

>>> rtl/rv32i_execute_unit.sv
// RV32I execute unit: register file, program counter and banked data memory.
// Depends on rv32ex_pkg for operation codes, trap codes and widths.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   op, dest_reg, src1_reg, src2_reg, immediate
//   rsp       out        rsp_valid/rsp_stall   reg_written, written_value, next_pc, trap
//   csr       in/out     psel/penable/pready   paddr, pwdata, prdata (start_address)
//
// One transaction is accepted per cycle while req_stall is low; it is registered at acceptance,
// then passes execute and memory access, then load alignment into the output register.
// After reset the data memory is cleared one row of four bytes per cycle;
// req_stall stays high until it is done.
// A stall on rsp backs up through the stages; empty stages still take new transactions.
// MEM_BYTES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_execute_unit #(
   parameter int unsigned MEM_BYTES = rv32ex_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_op,
   input  wire logic [4:0]  req_dest_reg,
   input  wire logic [4:0]  req_src1_reg,
   input  wire logic [4:0]  req_src2_reg,
   input  wire logic signed [20:0] req_immediate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_reg_written,
   output logic [31:0]      rsp_written_value,
   output logic [31:0]      rsp_next_pc,
   output logic [1:0]       rsp_trap,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned MEM_AW = $clog2(MEM_BYTES);
   localparam int unsigned ROWS   = MEM_BYTES / rv32ex_pkg::BANK_COUNT;
   localparam int unsigned ROW_W  = MEM_AW - 2;

   // Handshake and pipeline control.
   logic ready3, ready2, ready1, adv1, adv2, accept;
   logic v1_ff, v2_ff, v3_ff;
   logic clr_busy_ff;
   logic [ROW_W-1:0] clr_row_ff;

   // Architectural state.
   logic [31:0] start_ff, pc_ff;
   logic [31:0] rf_mem [rv32ex_pkg::REG_COUNT];
   logic [rv32ex_pkg::REG_COUNT-1:0] rf_vld_ff;
   logic rf_we, csr_we;

   // Operand stage registers.
   logic [5:0]  op1_ff;
   logic [4:0]  rd1_ff, src1_ff, src2_ff;
   logic signed [20:0] imm1_ff;
   logic [31:0] rf_q1_ff, rf_q2_ff, ovr1_val_ff, ovr2_val_ff;
   logic        vld1_ff, vld2_ff, ovr1_ff, ovr2_ff;

   // Execute signals.
   logic [31:0] op_a, op_b, imm_ext, upper_val, eff_addr, pc_plus4, br_target;
   logic [31:0] alu_val, npc_val;
   logic        fwd_a, fwd_b, wr_val, wr_eff, take, is_load, is_store;
   logic        lt_s, lt_u, lti_s, lti_u;
   logic [2:0]  st_bytes;
   rv32ex_pkg::trap_type trap_val;

   // Alignment stage registers.
   logic [5:0]  op2_ff;
   logic [4:0]  rd2_ff;
   logic [1:0]  alo2_ff;
   logic [31:0] val2_ff, npc2_ff;
   logic        wr2_ff, ld2_ff;
   logic [1:0]  trap2_ff;
   logic [7:0]  bank_q_ff [rv32ex_pkg::BANK_COUNT];
   logic [31:0] ld_word, load_val, p2_value;

   // Output registers.
   logic        wr3_ff;
   logic [31:0] val3_ff, npc3_ff;
   logic [1:0]  trap3_ff;

   assign ready3    = !v3_ff || !rsp_stall;
   assign adv2      = v2_ff && ready3;
   assign ready2    = !v2_ff || ready3;
   assign adv1      = v1_ff && ready2;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1 || clr_busy_ff;
   assign accept    = req_valid && !req_stall;

   assign csr_we = psel && penable && pwrite && (paddr[2] == rv32ex_pkg::CSR_START_ADDRESS);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == rv32ex_pkg::CSR_START_ADDRESS) ? start_ff : '0;

   assign rf_we = adv2 && wr2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
         rf_vld_ff   <= '0;
         start_ff    <= '0;
         pc_ff       <= '0;
      end else begin
         if (accept) begin
            v1_ff <= 1'b1;
         end else if (adv1) begin
            v1_ff <= 1'b0;
         end
         if (adv1) begin
            v2_ff <= 1'b1;
         end else if (adv2) begin
            v2_ff <= 1'b0;
         end
         if (adv2) begin
            v3_ff <= 1'b1;
         end else if (ready3) begin
            v3_ff <= 1'b0;
         end
         if (clr_busy_ff) begin
            clr_row_ff <= clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (rf_we) begin
            rf_vld_ff[rd2_ff] <= 1'b1;
         end
         if (csr_we) begin
            start_ff <= pwdata;
            pc_ff    <= pwdata;
         end else if (adv1) begin
            pc_ff <= npc_val;
         end
      end
   end

   // Register file: two reads at acceptance, one write as a result leaves alignment.
   always_ff @(posedge clock) begin
      if (accept) begin
         rf_q1_ff <= rf_mem[req_src1_reg];
         rf_q2_ff <= rf_mem[req_src2_reg];
      end
      if (rf_we) begin
         rf_mem[rd2_ff] <= p2_value;
      end
   end

   // The register write landing in the same edge as the read is caught here.
   always_ff @(posedge clock) begin
      if (accept) begin
         op1_ff      <= req_op;
         rd1_ff      <= req_dest_reg;
         src1_ff     <= req_src1_reg;
         src2_ff     <= req_src2_reg;
         imm1_ff     <= req_immediate;
         vld1_ff     <= rf_vld_ff[req_src1_reg];
         vld2_ff     <= rf_vld_ff[req_src2_reg];
         ovr1_ff     <= rf_we && (rd2_ff == req_src1_reg);
         ovr2_ff     <= rf_we && (rd2_ff == req_src2_reg);
         ovr1_val_ff <= p2_value;
         ovr2_val_ff <= p2_value;
      end
   end

   always_comb begin
      fwd_a = v2_ff && wr2_ff && (rd2_ff == src1_ff);
      fwd_b = v2_ff && wr2_ff && (rd2_ff == src2_ff);
      if (fwd_a) begin
         op_a = p2_value;
      end else if (ovr1_ff) begin
         op_a = ovr1_val_ff;
      end else begin
         op_a = vld1_ff ? rf_q1_ff : '0;
      end
      if (fwd_b) begin
         op_b = p2_value;
      end else if (ovr2_ff) begin
         op_b = ovr2_val_ff;
      end else begin
         op_b = vld2_ff ? rf_q2_ff : '0;
      end
   end

   always_comb begin
      imm_ext   = 32'(imm1_ff);
      upper_val = {imm1_ff[rv32ex_pkg::UPPER_WIDTH-1:0], {rv32ex_pkg::UPPER_SHIFT{1'b0}}};
      eff_addr  = op_a + imm_ext;
      pc_plus4  = pc_ff + 32'd4;
      br_target = pc_ff + imm_ext;
      lt_s      = $signed(op_a) < $signed(op_b);
      lt_u      = op_a < op_b;
      lti_s     = $signed(op_a) < $signed(imm_ext);
      lti_u     = op_a < imm_ext;

      alu_val  = '0;
      wr_val   = 1'b0;
      take     = 1'b0;
      is_load  = 1'b0;
      is_store = 1'b0;
      st_bytes = 3'd0;
      trap_val = rv32ex_pkg::TRAP_NONE;
      npc_val  = pc_plus4;

      case (op1_ff)
         rv32ex_pkg::OP_ADD: begin alu_val = op_a + op_b; wr_val = 1'b1; end
         rv32ex_pkg::OP_SUB: begin alu_val = op_a - op_b; wr_val = 1'b1; end
         rv32ex_pkg::OP_XOR: begin alu_val = op_a ^ op_b; wr_val = 1'b1; end
         rv32ex_pkg::OP_OR:  begin alu_val = op_a | op_b; wr_val = 1'b1; end
         rv32ex_pkg::OP_AND: begin alu_val = op_a & op_b; wr_val = 1'b1; end
         rv32ex_pkg::OP_SLL: begin alu_val = op_a << op_b[4:0]; wr_val = 1'b1; end
         rv32ex_pkg::OP_SRL: begin alu_val = op_a >> op_b[4:0]; wr_val = 1'b1; end
         rv32ex_pkg::OP_SRA: begin
            alu_val = 32'($signed(op_a) >>> op_b[4:0]);
            wr_val  = 1'b1;
         end
         rv32ex_pkg::OP_SLT:   begin alu_val = 32'(lt_s); wr_val = 1'b1; end
         rv32ex_pkg::OP_SLTU:  begin alu_val = 32'(lt_u); wr_val = 1'b1; end
         rv32ex_pkg::OP_ADDI:  begin alu_val = eff_addr; wr_val = 1'b1; end
         rv32ex_pkg::OP_XORI:  begin alu_val = op_a ^ imm_ext; wr_val = 1'b1; end
         rv32ex_pkg::OP_ORI:   begin alu_val = op_a | imm_ext; wr_val = 1'b1; end
         rv32ex_pkg::OP_ANDI:  begin alu_val = op_a & imm_ext; wr_val = 1'b1; end
         rv32ex_pkg::OP_SLLI:  begin alu_val = op_a << imm_ext[4:0]; wr_val = 1'b1; end
         rv32ex_pkg::OP_SRLI:  begin alu_val = op_a >> imm_ext[4:0]; wr_val = 1'b1; end
         rv32ex_pkg::OP_SRAI: begin
            alu_val = 32'($signed(op_a) >>> imm_ext[4:0]);
            wr_val  = 1'b1;
         end
         rv32ex_pkg::OP_SLTI:  begin alu_val = 32'(lti_s); wr_val = 1'b1; end
         rv32ex_pkg::OP_SLTIU: begin alu_val = 32'(lti_u); wr_val = 1'b1; end
         rv32ex_pkg::OP_LB, rv32ex_pkg::OP_LH, rv32ex_pkg::OP_LW,
         rv32ex_pkg::OP_LBU, rv32ex_pkg::OP_LHU: begin
            wr_val  = 1'b1;
            is_load = 1'b1;
         end
         rv32ex_pkg::OP_JALR: begin
            alu_val = pc_plus4;
            wr_val  = 1'b1;
            npc_val = {eff_addr[31:1], 1'b0};
         end
         rv32ex_pkg::OP_ECALL:  trap_val = rv32ex_pkg::TRAP_ECALL;
         rv32ex_pkg::OP_EBREAK: trap_val = rv32ex_pkg::TRAP_BREAK;
         rv32ex_pkg::OP_SB: begin is_store = 1'b1; st_bytes = 3'd1; end
         rv32ex_pkg::OP_SH: begin is_store = 1'b1; st_bytes = 3'd2; end
         rv32ex_pkg::OP_SW: begin is_store = 1'b1; st_bytes = 3'd4; end
         rv32ex_pkg::OP_BEQ:  take = (op_a == op_b);
         rv32ex_pkg::OP_BNE:  take = (op_a != op_b);
         rv32ex_pkg::OP_BLT:  take = lt_s;
         rv32ex_pkg::OP_BGE:  take = !lt_s;
         rv32ex_pkg::OP_BLTU: take = lt_u;
         rv32ex_pkg::OP_BGEU: take = !lt_u;
         rv32ex_pkg::OP_LUI:   begin alu_val = upper_val; wr_val = 1'b1; end
         rv32ex_pkg::OP_AUIPC: begin alu_val = pc_ff + upper_val; wr_val = 1'b1; end
         rv32ex_pkg::OP_JAL: begin
            alu_val = pc_plus4;
            wr_val  = 1'b1;
            npc_val = br_target;
         end
         default: begin
            alu_val = '0;
         end
      endcase

      if (take) begin
         npc_val = br_target;
      end
      wr_eff = wr_val && (rd1_ff != '0);
   end

   // Data memory: four byte banks, so any aligned or unaligned access touches
   // each bank at most once. A bank below the low address bits sits one row up.
   for (genvar j = 0; j < rv32ex_pkg::BANK_COUNT; j++) begin : g_bank
      logic [7:0]       bank_mem [ROWS];
      logic [1:0]       k_sel;
      logic [ROW_W-1:0] row_sel, row_wr;
      logic             bank_we;
      logic [7:0]       bank_wd;

      assign k_sel   = 2'(j) - eff_addr[1:0];
      assign row_sel = eff_addr[MEM_AW-1:2] + ROW_W'(2'(j) < eff_addr[1:0]);
      assign bank_we = clr_busy_ff || (adv1 && is_store && ({1'b0, k_sel} < st_bytes));
      assign row_wr  = clr_busy_ff ? clr_row_ff : row_sel;
      assign bank_wd = clr_busy_ff ? 8'h00 : op_b[{k_sel, 3'b000} +: 8];

      always_ff @(posedge clock) begin
         if (bank_we) begin
            bank_mem[row_wr] <= bank_wd;
         end
         if (adv1 && is_load) begin
            bank_q_ff[j] <= bank_mem[row_sel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         op2_ff   <= op1_ff;
         rd2_ff   <= rd1_ff;
         alo2_ff  <= eff_addr[1:0];
         val2_ff  <= wr_eff ? alu_val : '0;
         npc2_ff  <= npc_val;
         wr2_ff   <= wr_eff;
         ld2_ff   <= is_load;
         trap2_ff <= trap_val;
      end
   end

   always_comb begin
      for (int k = 0; k < rv32ex_pkg::BANK_COUNT; k++) begin
         ld_word[8*k +: 8] = bank_q_ff[2'(alo2_ff + 2'(k))];
      end
      case (op2_ff)
         rv32ex_pkg::OP_LB:  load_val = 32'($signed(ld_word[7:0]));
         rv32ex_pkg::OP_LH:  load_val = 32'($signed(ld_word[15:0]));
         rv32ex_pkg::OP_LBU: load_val = 32'(ld_word[7:0]);
         rv32ex_pkg::OP_LHU: load_val = 32'(ld_word[15:0]);
         default:            load_val = ld_word;
      endcase
      if (!wr2_ff) begin
         p2_value = '0;
      end else begin
         p2_value = ld2_ff ? load_val : val2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         wr3_ff   <= wr2_ff;
         val3_ff  <= p2_value;
         npc3_ff  <= npc2_ff;
         trap3_ff <= trap2_ff;
      end
   end

   assign rsp_valid         = v3_ff;
   assign rsp_reg_written   = wr3_ff;
   assign rsp_written_value = val3_ff;
   assign rsp_next_pc       = npc3_ff;
   assign rsp_trap          = trap3_ff;

endmodule

`default_nettype wire

>>> verif/rv32i_execute_unit_test.sv
// Self-checking testbench for rv32i_execute_unit: directed and random instruction streams,
// with random idle and stall on both channels, checked against an in-bench executor.
// Depends on rv32ex_pkg and rv32i_execute_unit.
`timescale 1ns / 1ps

module rv32i_execute_unit_test;

   localparam int unsigned XLEN          = rv32ex_pkg::XLEN;
   localparam int unsigned OP_WIDTH      = rv32ex_pkg::OP_WIDTH;
   localparam int unsigned REG_IDX_WIDTH = rv32ex_pkg::REG_IDX_WIDTH;
   localparam int unsigned REG_COUNT     = rv32ex_pkg::REG_COUNT;
   localparam int unsigned IMM_WIDTH     = rv32ex_pkg::IMM_WIDTH;
   localparam int unsigned UPPER_WIDTH   = rv32ex_pkg::UPPER_WIDTH;
   localparam int unsigned UPPER_SHIFT   = rv32ex_pkg::UPPER_SHIFT;
   localparam int unsigned TRAP_WIDTH    = rv32ex_pkg::TRAP_WIDTH;
   localparam int unsigned CSR_ADDR_WIDTH = rv32ex_pkg::CSR_ADDR_WIDTH;

   localparam int unsigned MEM_SIZE = rv32ex_pkg::MEM_BYTES_DEFAULT;
   localparam int unsigned RANDOM_PER_PHASE = 290;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned FIRST_UNUSED_OP = rv32ex_pkg::OP_JAL + 1;
   localparam int unsigned LAST_OP_CODE = (1 << OP_WIDTH) - 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] START_ADDRESS_PADDR =
      {rv32ex_pkg::CSR_START_ADDRESS, 2'b00};

   typedef struct packed {
      logic [OP_WIDTH-1:0]      op;
      logic [REG_IDX_WIDTH-1:0] dest;
      logic [REG_IDX_WIDTH-1:0] src1;
      logic [REG_IDX_WIDTH-1:0] src2;
      logic signed [IMM_WIDTH-1:0] imm;
   } instr_type;

   typedef struct packed {
      logic                  reg_written;
      logic [XLEN-1:0]       written_value;
      logic [XLEN-1:0]       next_pc;
      logic [TRAP_WIDTH-1:0] trap;
   } retire_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [5:0] req_op = '0;
   logic [4:0] req_dest_reg = '0;
   logic [4:0] req_src1_reg = '0;
   logic [4:0] req_src2_reg = '0;
   logic signed [20:0] req_immediate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_reg_written;
   logic [31:0] rsp_written_value;
   logic [31:0] rsp_next_pc;
   logic [1:0] rsp_trap;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   rv32i_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_dest_reg(req_dest_reg), .req_src1_reg(req_src1_reg),
      .req_src2_reg(req_src2_reg), .req_immediate(req_immediate),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reg_written(rsp_reg_written),
      .rsp_written_value(rsp_written_value), .rsp_next_pc(rsp_next_pc),
      .rsp_trap(rsp_trap),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Architectural state as the executor sees it.
   logic [XLEN-1:0] gpr [REG_COUNT];
   logic [7:0] data_bytes [MEM_SIZE];
   logic [XLEN-1:0] program_counter;
   logic [XLEN-1:0] start_address;

   instr_type pending_instrs[$];
   retire_type expected_retires[$];
   int unsigned failures = 0;
   int unsigned send_gap = 0;
   int unsigned hold_left = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   logic signed [IMM_WIDTH-1:0] last_store_imm = '0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Mostly short gaps, a few long ones, none at all during a calm stretch.
   function automatic int unsigned idle_length(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [XLEN-1:0] load_bytes(input logic [XLEN-1:0] addr,
                                                  input int unsigned count);
      logic [XLEN-1:0] v;
      logic [XLEN-1:0] byte_addr;
      v = '0;
      for (int unsigned k = 0; k < count; k++) begin
         byte_addr = addr + k;
         v |= XLEN'(data_bytes[byte_addr % MEM_SIZE]) << (8 * k);
      end
      return v;
   endfunction

   function automatic void store_bytes(input logic [XLEN-1:0] addr, input int unsigned count,
                                       input logic [XLEN-1:0] v);
      logic [XLEN-1:0] byte_addr;
      for (int unsigned k = 0; k < count; k++) begin
         byte_addr = addr + k;
         data_bytes[byte_addr % MEM_SIZE] = v[8*k +: 8];
      end
   endfunction

   // Executes one instruction against the bench state and returns what should retire.
   function automatic retire_type retire_instruction(input instr_type t);
      retire_type r;
      logic [XLEN-1:0] a, b, imm, upper, npc, val, addr, v;
      logic wr, take;
      logic [TRAP_WIDTH-1:0] trap;
      a = gpr[t.src1];
      b = gpr[t.src2];
      imm = {{(XLEN-IMM_WIDTH){t.imm[IMM_WIDTH-1]}}, t.imm};
      upper = {t.imm[UPPER_WIDTH-1:0], {UPPER_SHIFT{1'b0}}};
      npc = program_counter + 4;
      val = '0;
      addr = a + imm;
      wr = 1'b1;
      take = 1'b0;
      trap = rv32ex_pkg::TRAP_NONE;
      case (t.op)
         rv32ex_pkg::OP_ADD:   val = a + b;
         rv32ex_pkg::OP_SUB:   val = a - b;
         rv32ex_pkg::OP_XOR:   val = a ^ b;
         rv32ex_pkg::OP_OR:    val = a | b;
         rv32ex_pkg::OP_AND:   val = a & b;
         rv32ex_pkg::OP_SLL:   val = a << b[4:0];
         rv32ex_pkg::OP_SRL:   val = a >> b[4:0];
         rv32ex_pkg::OP_SRA:   val = $signed(a) >>> b[4:0];
         rv32ex_pkg::OP_SLT:   val = XLEN'($signed(a) < $signed(b));
         rv32ex_pkg::OP_SLTU:  val = XLEN'(a < b);
         rv32ex_pkg::OP_ADDI:  val = a + imm;
         rv32ex_pkg::OP_XORI:  val = a ^ imm;
         rv32ex_pkg::OP_ORI:   val = a | imm;
         rv32ex_pkg::OP_ANDI:  val = a & imm;
         rv32ex_pkg::OP_SLLI:  val = a << imm[4:0];
         rv32ex_pkg::OP_SRLI:  val = a >> imm[4:0];
         rv32ex_pkg::OP_SRAI:  val = $signed(a) >>> imm[4:0];
         rv32ex_pkg::OP_SLTI:  val = XLEN'($signed(a) < $signed(imm));
         rv32ex_pkg::OP_SLTIU: val = XLEN'(a < imm);
         rv32ex_pkg::OP_LB: begin
            v = load_bytes(addr, 1);
            val = {{24{v[7]}}, v[7:0]};
         end
         rv32ex_pkg::OP_LH: begin
            v = load_bytes(addr, 2);
            val = {{16{v[15]}}, v[15:0]};
         end
         rv32ex_pkg::OP_LW:    val = load_bytes(addr, 4);
         rv32ex_pkg::OP_LBU:   val = load_bytes(addr, 1);
         rv32ex_pkg::OP_LHU:   val = load_bytes(addr, 2);
         rv32ex_pkg::OP_JALR: begin
            val = program_counter + 4;
            npc = addr & ~XLEN'(1);
         end
         rv32ex_pkg::OP_ECALL: begin
            wr = 1'b0;
            trap = rv32ex_pkg::TRAP_ECALL;
         end
         rv32ex_pkg::OP_EBREAK: begin
            wr = 1'b0;
            trap = rv32ex_pkg::TRAP_BREAK;
         end
         rv32ex_pkg::OP_SB: begin
            wr = 1'b0;
            store_bytes(addr, 1, b);
         end
         rv32ex_pkg::OP_SH: begin
            wr = 1'b0;
            store_bytes(addr, 2, b);
         end
         rv32ex_pkg::OP_SW: begin
            wr = 1'b0;
            store_bytes(addr, 4, b);
         end
         rv32ex_pkg::OP_BEQ: begin
            wr = 1'b0;
            take = (a == b);
         end
         rv32ex_pkg::OP_BNE: begin
            wr = 1'b0;
            take = (a != b);
         end
         rv32ex_pkg::OP_BLT: begin
            wr = 1'b0;
            take = $signed(a) < $signed(b);
         end
         rv32ex_pkg::OP_BGE: begin
            wr = 1'b0;
            take = $signed(a) >= $signed(b);
         end
         rv32ex_pkg::OP_BLTU: begin
            wr = 1'b0;
            take = (a < b);
         end
         rv32ex_pkg::OP_BGEU: begin
            wr = 1'b0;
            take = (a >= b);
         end
         rv32ex_pkg::OP_LUI:   val = upper;
         rv32ex_pkg::OP_AUIPC: val = program_counter + upper;
         rv32ex_pkg::OP_JAL: begin
            val = program_counter + 4;
            npc = program_counter + imm;
         end
         default:  wr = 1'b0;
      endcase
      if (take) npc = program_counter + imm;
      if (t.dest == '0) wr = 1'b0;
      if (wr) gpr[t.dest] = val;
      else val = '0;
      program_counter = npc;
      r.reg_written = wr;
      r.written_value = val;
      r.next_pc = npc;
      r.trap = trap;
      return r;
   endfunction

   function automatic instr_type random_instruction();
      instr_type t;
      int unsigned pick;
      int signed short_imm;
      t.dest = 5'($urandom_range(0, REG_COUNT - 1));
      t.src1 = 5'($urandom_range(0, REG_COUNT - 1));
      t.src2 = 5'($urandom_range(0, REG_COUNT - 1));
      t.imm = 21'($urandom);
      short_imm = int'($urandom_range(0, 127)) - 64;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         t.op = 6'($urandom_range(rv32ex_pkg::OP_ADD, rv32ex_pkg::OP_SLTU));
      end else if (pick < 48) begin
         t.op = 6'($urandom_range(rv32ex_pkg::OP_ADDI, rv32ex_pkg::OP_SLTIU));
         if ($urandom_range(0, 1) == 0) t.imm = 21'(int'($urandom_range(0, 4095)) - 2048);
      end else if (pick < 60) begin
         t.op = 6'($urandom_range(rv32ex_pkg::OP_LB, rv32ex_pkg::OP_LHU));
         pick = $urandom_range(0, 9);
         // Loads mostly revisit a small window around address zero where stores land,
         // often exactly the last store's address.
         if (pick < 4) begin
            t.src1 = '0;
            t.imm = last_store_imm;
         end else if (pick < 7) begin
            t.src1 = '0;
            t.imm = 21'(short_imm);
         end
      end else if (pick < 70) begin
         t.op = 6'($urandom_range(rv32ex_pkg::OP_SB, rv32ex_pkg::OP_SW));
         if ($urandom_range(0, 9) < 7) begin
            t.src1 = '0;
            t.imm = 21'(short_imm);
            last_store_imm = t.imm;
         end
      end else if (pick < 80) begin
         t.op = 6'($urandom_range(rv32ex_pkg::OP_BEQ, rv32ex_pkg::OP_BGEU));
         if ($urandom_range(0, 3) == 0) t.src2 = t.src1;
      end else if (pick < 86) begin
         t.op = $urandom_range(0, 1) ? rv32ex_pkg::OP_LUI : rv32ex_pkg::OP_AUIPC;
      end else if (pick < 90) begin
         t.op = $urandom_range(0, 1) ? rv32ex_pkg::OP_JAL : rv32ex_pkg::OP_JALR;
      end else if (pick < 93) begin
         t.op = $urandom_range(0, 1) ? rv32ex_pkg::OP_ECALL : rv32ex_pkg::OP_EBREAK;
      end else if (pick < 96) begin
         t.op = 6'($urandom_range(FIRST_UNUSED_OP, LAST_OP_CODE));
      end else begin
         t.op = 6'($urandom_range(0, LAST_OP_CODE));
      end
      return t;
   endfunction

   function automatic void queue_instr(input logic [OP_WIDTH-1:0] op,
                                       input int unsigned rd, input int unsigned rs1,
                                       input int unsigned rs2, input int signed imm);
      instr_type t;
      t.op = op;
      t.dest = 5'(rd);
      t.src1 = 5'(rs1);
      t.src2 = 5'(rs2);
      t.imm = 21'(imm);
      pending_instrs.push_back(t);
   endfunction

   task automatic queue_random(input int unsigned count);
      @(negedge clock);
      repeat (count) pending_instrs.push_back(random_instruction());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_instrs.size() != 0 || req_valid || expected_retires.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_start_address();
      logic [31:0] readback;
      csr_access(1'b0, START_ADDRESS_PADDR, '0, readback);
      if (readback !== start_address) begin
         failures++;
         $display("%0t: start_address readback expected %h actual %h",
                  $time, start_address, readback);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : request_driver
      instr_type t;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_instrs.size() > 0) begin
            t = pending_instrs.pop_front();
            req_op <= t.op;
            req_dest_reg <= t.dest;
            req_src1_reg <= t.src1;
            req_src2_reg <= t.src2;
            req_immediate <= t.imm;
            req_valid <= 1'b1;
            if ($urandom_range(0, 99) == 0) req_calm = !req_calm;
            send_gap = idle_length(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_stall
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
            rsp_stall <= 1'b1;
            hold_left = idle_length(1'b0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      instr_type t;
      retire_type e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            t.op = req_op;
            t.dest = req_dest_reg;
            t.src1 = req_src1_reg;
            t.src2 = req_src2_reg;
            t.imm = req_immediate;
            expected_retires.push_back(retire_instruction(t));
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_retires.size() == 0) begin
               failures++;
               $display("%0t: result transaction with nothing outstanding", $time);
            end else begin
               e = expected_retires.pop_front();
               if (rsp_reg_written !== e.reg_written)
                  report_mismatch("reg_written", 32'(e.reg_written), 32'(rsp_reg_written));
               if (rsp_written_value !== e.written_value)
                  report_mismatch("written_value", e.written_value, rsp_written_value);
               if (rsp_next_pc !== e.next_pc)
                  report_mismatch("next_pc", e.next_pc, rsp_next_pc);
               if (rsp_trap !== e.trap)
                  report_mismatch("trap", 32'(e.trap), 32'(rsp_trap));
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0] start_values [5];
      logic [31:0] unused;
      start_values[0] = 32'hFFFF_FFFF;
      start_values[1] = $urandom;
      start_values[2] = 32'h0000_0000;
      start_values[3] = 32'h8000_0000;
      start_values[4] = $urandom;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (data_bytes[i]) data_bytes[i] = '0;
      start_address = '0;
      program_counter = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      check_start_address();

      @(negedge clock);
      // Extreme values, shifts by 31, compares across the sign bit, accesses that wrap
      // around the end of memory, writes to x0, jumps that wrap the pc, traps, no-ops.
      queue_instr(rv32ex_pkg::OP_LUI, 1, 0, 0, 'h0FFFFF);
      queue_instr(rv32ex_pkg::OP_LUI, 20, 0, 0, -1);
      queue_instr(rv32ex_pkg::OP_ADDI, 2, 0, 0, -1);
      queue_instr(rv32ex_pkg::OP_ADDI, 3, 0, 0, -1048576);
      queue_instr(rv32ex_pkg::OP_ADDI, 4, 0, 0, 1048575);
      queue_instr(rv32ex_pkg::OP_SRA, 5, 1, 2, 0);
      queue_instr(rv32ex_pkg::OP_SRAI, 6, 1, 0, -28);
      queue_instr(rv32ex_pkg::OP_SRL, 7, 1, 2, 0);
      queue_instr(rv32ex_pkg::OP_SLL, 8, 2, 2, 0);
      queue_instr(rv32ex_pkg::OP_SLT, 9, 1, 4, 0);
      queue_instr(rv32ex_pkg::OP_SLTIU, 10, 4, 0, -1);
      queue_instr(rv32ex_pkg::OP_SW, 0, 0, 4, -2);
      queue_instr(rv32ex_pkg::OP_LW, 11, 0, 0, -2);
      queue_instr(rv32ex_pkg::OP_LB, 12, 0, 0, -1);
      queue_instr(rv32ex_pkg::OP_LHU, 13, 0, 0, -1);
      queue_instr(rv32ex_pkg::OP_SB, 0, 0, 2, 1);
      queue_instr(rv32ex_pkg::OP_LH, 14, 0, 0, 0);
      queue_instr(rv32ex_pkg::OP_ADD, 0, 2, 2, 0);
      queue_instr(rv32ex_pkg::OP_JALR, 15, 2, 0, 0);
      queue_instr(rv32ex_pkg::OP_AUIPC, 16, 0, 0, 'h0FFFFF);
      queue_instr(rv32ex_pkg::OP_JAL, 17, 0, 0, -1048576);
      queue_instr(rv32ex_pkg::OP_BEQ, 0, 0, 0, 8);
      queue_instr(rv32ex_pkg::OP_BLTU, 0, 4, 1, -4);
      queue_instr(rv32ex_pkg::OP_BGE, 0, 1, 4, 16);
      queue_instr(rv32ex_pkg::OP_ECALL, 0, 0, 0, 0);
      queue_instr(rv32ex_pkg::OP_EBREAK, 0, 0, 0, 0);
      queue_instr(6'(LAST_OP_CODE), 18, 2, 2, -1);
      queue_random(RANDOM_PER_PHASE);
      wait_drained();

      foreach (start_values[i]) begin
         // Let the pipeline settle before the start address is written.
         repeat (6) @(posedge clock);
         csr_access(1'b1, START_ADDRESS_PADDR, start_values[i], unused);
         start_address = start_values[i];
         program_counter = start_values[i];
         check_start_address();
         queue_random(RANDOM_PER_PHASE);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_retires.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
